/* design/obb_sat_pkg.sv */
// Shared types, widths and sine table helper for the oriented box SAT engine.
package obb_sat_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int TRIG_DEPTH_DEF = 1024;

    localparam int TRIG_W  = 16;  // Q1.14 sine and cosine
    localparam int COORD_W = 40;  // corner coordinate, Q14 scaled
    localparam int MUL_W   = 56;  // corner times axis component
    localparam int PROJ_W  = 57;  // projection onto one axis
    localparam int OVL_W   = 58;  // overlap on one axis
    localparam int NUM_AXES = 4;
    localparam int NUM_CORNERS = 4;

    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef logic signed [TRIG_W-1:0]  t_trig;
    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [MUL_W-1:0]   t_mul;
    typedef logic signed [PROJ_W-1:0]  t_proj;
    typedef logic signed [OVL_W-1:0]   t_ovl;

    typedef struct packed {
        logic signed [23:0] a_pos_x;
        logic signed [23:0] a_pos_y;
        logic [19:0]        a_width;
        logic [19:0]        a_height;
        logic [15:0]        a_angle;
        logic signed [23:0] b_pos_x;
        logic signed [23:0] b_pos_y;
        logic [19:0]        b_width;
        logic [19:0]        b_height;
        logic [15:0]        b_angle;
    } t_in;

    typedef struct packed {
        logic               hit;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic [23:0]        overlap;
    } t_out;

    // Sine of a first-quadrant angle x (Q30 radians) by an odd Taylor series,
    // rounded to Q14 and clamped, negated for the lower half turn.
    function automatic t_trig q14_of(input longint unsigned x, input logic neg);
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned q;
        x2 = (x * x) >> 30;
        t  = Q30_ONE - x2 / 72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 6;
        s  = (x * t) >> 30;
        q  = (s + 64'd32768) >> 16;
        if (q > 64'd16384) begin
            q = 64'd16384;
        end
        return neg ? -TRIG_W'(q) : TRIG_W'(q);
    endfunction

endpackage

/* design/obb_sat_trig.sv */
// Angle to table index and registered sine/cosine ROM lookup for both boxes.
module obb_sat_trig
    import obb_sat_pkg::*;
#(
    parameter int ANGLE_BITS       = ANGLE_BITS_DEF,
    parameter int TRIG_TABLE_DEPTH = TRIG_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [15:0] i_a_angle,
    input  logic [15:0] i_b_angle,
    output t_trig       o_a_sin,
    output t_trig       o_a_cos,
    output t_trig       o_b_sin,
    output t_trig       o_b_cos
);

    localparam int IW = $clog2(TRIG_TABLE_DEPTH);
    localparam int PW = ANGLE_BITS + IW + 1;
    localparam longint unsigned DL = longint'(TRIG_TABLE_DEPTH);

    t_trig w_sin [TRIG_TABLE_DEPTH];
    t_trig w_cos [TRIG_TABLE_DEPTH];

    for (genvar i = 0; i < TRIG_TABLE_DEPTH; i++) begin : g_rom
        localparam longint unsigned US = 64'(4 * i);
        localparam longint unsigned KS = (US / DL) % 4;
        localparam longint unsigned RS = US % DL;
        localparam longint unsigned XS = (((KS % 2) == 1 ? DL - RS : RS) * HALF_PI_Q30) / DL;
        localparam longint unsigned UC = (US + DL) % (4 * DL);
        localparam longint unsigned KC = (UC / DL) % 4;
        localparam longint unsigned RC = UC % DL;
        localparam longint unsigned XC = (((KC % 2) == 1 ? DL - RC : RC) * HALF_PI_Q30) / DL;
        assign w_sin[i] = q14_of(XS, KS >= 2);
        assign w_cos[i] = q14_of(XC, KC >= 2);
    end

    logic [ANGLE_BITS-1:0] w_ang_a;
    logic [ANGLE_BITS-1:0] w_ang_b;
    logic [PW-1:0]         w_prod_a;
    logic [PW-1:0]         w_prod_b;
    logic [IW-1:0]         w_idx_a;
    logic [IW-1:0]         w_idx_b;

    assign w_ang_a  = ANGLE_BITS'(i_a_angle);
    assign w_ang_b  = ANGLE_BITS'(i_b_angle);
    assign w_prod_a = PW'(w_ang_a) * PW'(TRIG_TABLE_DEPTH);
    assign w_prod_b = PW'(w_ang_b) * PW'(TRIG_TABLE_DEPTH);
    assign w_idx_a  = w_prod_a[ANGLE_BITS +: IW];
    assign w_idx_b  = w_prod_b[ANGLE_BITS +: IW];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_a_sin <= w_sin[w_idx_a];
            o_a_cos <= w_cos[w_idx_a];
            o_b_sin <= w_sin[w_idx_b];
            o_b_cos <= w_cos[w_idx_b];
        end
    end

endmodule

/* design/obb_sat_corner.sv */
// Builds the four rotated corners of one box in two registered stages.
module obb_sat_corner
    import obb_sat_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en_mul,
    input  logic               i_en_sum,
    input  logic signed [23:0] i_pos_x,
    input  logic signed [23:0] i_pos_y,
    input  logic [19:0]        i_width,
    input  logic [19:0]        i_height,
    input  t_trig              i_cos,
    input  t_trig              i_sin,
    output t_coord             o_cx [NUM_CORNERS],
    output t_coord             o_cy [NUM_CORNERS],
    output t_trig              o_cos,
    output t_trig              o_sin
);

    logic signed [36:0] r_wc, r_ws, r_hc, r_hs;
    logic signed [23:0] r_px, r_py;
    t_trig              r_cos, r_sin;
    t_coord             w_bx, w_by;

    always_ff @(posedge i_clk) begin
        if (i_en_mul) begin
            r_wc  <= $signed({1'b0, i_width})  * i_cos;
            r_ws  <= $signed({1'b0, i_width})  * i_sin;
            r_hc  <= $signed({1'b0, i_height}) * i_cos;
            r_hs  <= $signed({1'b0, i_height}) * i_sin;
            r_px  <= i_pos_x;
            r_py  <= i_pos_y;
            r_cos <= i_cos;
            r_sin <= i_sin;
        end
    end

    assign w_bx = {{(COORD_W-38){r_px[23]}}, r_px, 14'd0};
    assign w_by = {{(COORD_W-38){r_py[23]}}, r_py, 14'd0};

    always_ff @(posedge i_clk) begin
        if (i_en_sum) begin
            o_cx[0] <= w_bx;
            o_cx[1] <= w_bx + COORD_W'(r_wc);
            o_cx[2] <= w_bx + COORD_W'(r_wc) - COORD_W'(r_hs);
            o_cx[3] <= w_bx - COORD_W'(r_hs);
            o_cy[0] <= w_by;
            o_cy[1] <= w_by + COORD_W'(r_ws);
            o_cy[2] <= w_by + COORD_W'(r_ws) + COORD_W'(r_hc);
            o_cy[3] <= w_by + COORD_W'(r_hc);
            o_cos   <= r_cos;
            o_sin   <= r_sin;
        end
    end

endmodule

/* design/obb_sat_lane.sv */
// One axis lane: projects both boxes onto its axis and finds their overlap.
module obb_sat_lane
    import obb_sat_pkg::*;
(
    input  logic       i_clk,
    input  logic [3:0] i_en,
    input  t_coord     i_cx [2*NUM_CORNERS],
    input  t_coord     i_cy [2*NUM_CORNERS],
    input  t_trig      i_ax,
    input  t_trig      i_ay,
    output t_ovl       o_ovl,
    output t_trig      o_ax,
    output t_trig      o_ay
);

    t_mul  r_mx [2*NUM_CORNERS];
    t_mul  r_my [2*NUM_CORNERS];
    t_proj r_pj [2*NUM_CORNERS];
    t_proj r_lo_a, r_hi_a, r_lo_b, r_hi_b;
    t_trig r_ax [3];
    t_trig r_ay [3];
    t_proj w_lo_a, w_hi_a, w_lo_b, w_hi_b;
    t_proj w_hi, w_lo;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int j = 0; j < 2*NUM_CORNERS; j++) begin
                r_mx[j] <= i_cx[j] * i_ax;
                r_my[j] <= i_cy[j] * i_ay;
            end
            r_ax[0] <= i_ax;
            r_ay[0] <= i_ay;
        end
        if (i_en[1]) begin
            for (int j = 0; j < 2*NUM_CORNERS; j++) begin
                r_pj[j] <= PROJ_W'(r_mx[j]) + PROJ_W'(r_my[j]);
            end
            r_ax[1] <= r_ax[0];
            r_ay[1] <= r_ay[0];
        end
        if (i_en[2]) begin
            r_lo_a  <= w_lo_a;
            r_hi_a  <= w_hi_a;
            r_lo_b  <= w_lo_b;
            r_hi_b  <= w_hi_b;
            r_ax[2] <= r_ax[1];
            r_ay[2] <= r_ay[1];
        end
        if (i_en[3]) begin
            o_ovl <= OVL_W'(w_hi) - OVL_W'(w_lo);
            o_ax  <= r_ax[2];
            o_ay  <= r_ay[2];
        end
    end

    always_comb begin
        w_lo_a = r_pj[0];
        w_hi_a = r_pj[0];
        w_lo_b = r_pj[NUM_CORNERS];
        w_hi_b = r_pj[NUM_CORNERS];
        for (int j = 1; j < NUM_CORNERS; j++) begin
            if (r_pj[j] < w_lo_a) w_lo_a = r_pj[j];
            if (r_pj[j] > w_hi_a) w_hi_a = r_pj[j];
            if (r_pj[NUM_CORNERS+j] < w_lo_b) w_lo_b = r_pj[NUM_CORNERS+j];
            if (r_pj[NUM_CORNERS+j] > w_hi_b) w_hi_b = r_pj[NUM_CORNERS+j];
        end
        w_hi = (r_hi_a < r_hi_b) ? r_hi_a : r_hi_b;
        w_lo = (r_lo_a > r_lo_b) ? r_lo_a : r_lo_b;
    end

endmodule

/* design/obb_sat_merge.sv */
// Merges the four lane overlaps into the hit flag, least axis and rounded depth.
module obb_sat_merge
    import obb_sat_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en,
    input  t_ovl  i_ovl [NUM_AXES],
    input  t_trig i_ax [NUM_AXES],
    input  t_trig i_ay [NUM_AXES],
    output t_out  o_data
);

    localparam int SUM_W = OVL_W + 1;

    logic             w_hit;
    t_ovl             w_best;
    t_trig            w_bx, w_by;
    logic [SUM_W-1:0] w_sum;
    logic [SUM_W-29:0] w_q;
    t_out             w_out;

    always_comb begin
        w_hit  = 1'b1;
        w_best = i_ovl[0];
        w_bx   = i_ax[0];
        w_by   = i_ay[0];
        for (int i = 0; i < NUM_AXES; i++) begin
            if (i_ovl[i] <= 0) w_hit = 1'b0;
        end
        // Strict compare so the earlier axis keeps a tie.
        for (int i = 1; i < NUM_AXES; i++) begin
            if (i_ovl[i] < w_best) begin
                w_best = i_ovl[i];
                w_bx   = i_ax[i];
                w_by   = i_ay[i];
            end
        end
        w_sum = SUM_W'($unsigned(w_best)) + (SUM_W'(1) << 27);
        w_q   = w_sum[SUM_W-1:28];
        w_out = '0;
        if (w_hit) begin
            w_out.hit     = 1'b1;
            w_out.axis_x  = w_bx;
            w_out.axis_y  = w_by;
            w_out.overlap = (w_q > (SUM_W-28)'(24'hFFFFFF)) ? 24'hFFFFFF : w_q[23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_data <= w_out;
        end
    end

endmodule

/* design/obb_sat_collision_mtv_top.sv */
// Throughput: one beat per cycle unless the output is held by i_out_ready;
// eight stages each with its own valid bit, and a stage loads whenever it
// is empty or the stage after it moves, so bubbles are squeezed out and
// input is taken while a result waits.
// Sine and cosine come from a registered ROM of TRIG_TABLE_DEPTH entries.
// Synchronous active-low reset clears all stage valid bits; data is not reset.
module obb_sat_collision_mtv_top
    import obb_sat_pkg::*;
#(
    parameter int ANGLE_BITS       = ANGLE_BITS_DEF,
    parameter int TRIG_TABLE_DEPTH = TRIG_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int NST = 8;

    logic [NST:1] r_v, n_v, w_en;
    t_in          r_s1;
    t_trig        w_a_sin, w_a_cos, w_b_sin, w_b_cos;
    t_coord       w_acx [NUM_CORNERS];
    t_coord       w_acy [NUM_CORNERS];
    t_coord       w_bcx [NUM_CORNERS];
    t_coord       w_bcy [NUM_CORNERS];
    t_coord       w_cx [2*NUM_CORNERS];
    t_coord       w_cy [2*NUM_CORNERS];
    t_trig        w_ca, w_sa, w_cb, w_sb;
    t_trig        w_axin [NUM_AXES];
    t_trig        w_ayin [NUM_AXES];
    t_ovl         w_ovl [NUM_AXES];
    t_trig        w_ax [NUM_AXES];
    t_trig        w_ay [NUM_AXES];

    always_comb begin
        w_en[NST] = !r_v[NST] || i_out_ready;
        for (int k = NST-1; k >= 1; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
        n_v = r_v;
        for (int k = 1; k <= NST; k++) begin
            if (w_en[k]) n_v[k] = (k == 1) ? i_in_valid : r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_s1 <= i_in_data;
        end
    end

    assign o_in_ready  = w_en[1];
    assign o_out_valid = r_v[NST];

    obb_sat_trig #(
        .ANGLE_BITS       (ANGLE_BITS),
        .TRIG_TABLE_DEPTH (TRIG_TABLE_DEPTH)
    ) u_trig (
        .i_clk     (i_clk),
        .i_en      (w_en[1]),
        .i_a_angle (i_in_data.a_angle),
        .i_b_angle (i_in_data.b_angle),
        .o_a_sin   (w_a_sin),
        .o_a_cos   (w_a_cos),
        .o_b_sin   (w_b_sin),
        .o_b_cos   (w_b_cos)
    );

    obb_sat_corner u_corner_a (
        .i_clk    (i_clk),
        .i_en_mul (w_en[2]),
        .i_en_sum (w_en[3]),
        .i_pos_x  (r_s1.a_pos_x),
        .i_pos_y  (r_s1.a_pos_y),
        .i_width  (r_s1.a_width),
        .i_height (r_s1.a_height),
        .i_cos    (w_a_cos),
        .i_sin    (w_a_sin),
        .o_cx     (w_acx),
        .o_cy     (w_acy),
        .o_cos    (w_ca),
        .o_sin    (w_sa)
    );

    obb_sat_corner u_corner_b (
        .i_clk    (i_clk),
        .i_en_mul (w_en[2]),
        .i_en_sum (w_en[3]),
        .i_pos_x  (r_s1.b_pos_x),
        .i_pos_y  (r_s1.b_pos_y),
        .i_width  (r_s1.b_width),
        .i_height (r_s1.b_height),
        .i_cos    (w_b_cos),
        .i_sin    (w_b_sin),
        .o_cx     (w_bcx),
        .o_cy     (w_bcy),
        .o_cos    (w_cb),
        .o_sin    (w_sb)
    );

    always_comb begin
        for (int j = 0; j < NUM_CORNERS; j++) begin
            w_cx[j]             = w_acx[j];
            w_cy[j]             = w_acy[j];
            w_cx[NUM_CORNERS+j] = w_bcx[j];
            w_cy[NUM_CORNERS+j] = w_bcy[j];
        end
        // Edge normals in order: A width, A height, B width, B height.
        w_axin[0] = -w_sa; w_ayin[0] = w_ca;
        w_axin[1] = -w_ca; w_ayin[1] = -w_sa;
        w_axin[2] = -w_sb; w_ayin[2] = w_cb;
        w_axin[3] = -w_cb; w_ayin[3] = -w_sb;
    end

    for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
        obb_sat_lane u_lane (
            .i_clk (i_clk),
            .i_en  (w_en[7:4]),
            .i_cx  (w_cx),
            .i_cy  (w_cy),
            .i_ax  (w_axin[g]),
            .i_ay  (w_ayin[g]),
            .o_ovl (w_ovl[g]),
            .o_ax  (w_ax[g]),
            .o_ay  (w_ay[g])
        );
    end

    obb_sat_merge u_merge (
        .i_clk  (i_clk),
        .i_en   (w_en[NST]),
        .i_ovl  (w_ovl),
        .i_ax   (w_ax),
        .i_ay   (w_ay),
        .o_data (o_out_data)
    );

    a_stall_only_from_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled without output backpressure");

    a_miss_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.hit) |->
        (o_out_data.axis_x == 16'sd0 && o_out_data.axis_y == 16'sd0 &&
         o_out_data.overlap == 24'd0))
        else $error("miss result carries nonzero fields");

    a_full_pipe_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_out_ready) |=> r_v[1])
        else $error("accepted beat lost at first stage");

endmodule
